/* hw/rtl/cvs_pkg.sv */
// Package for the cyclic voltammetry sweep sequencer.
// Holds field widths, register indexes, action codes, the sweep phase type and shared structs.
// It has no dependencies.
`default_nettype none

package cvs_pkg;

  localparam int SP_W       = 23;
  localparam int CUR_W      = 24;
  localparam int STEP_W     = 20;
  localparam int CYC_W      = 16;
  localparam int PER_W      = 16;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] REG_BEGIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_V1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_V2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLES = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd5;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam logic [STEP_W-1:0] STEP_RESET   = 20'd1000;
  localparam logic [CYC_W-1:0]  CYCLES_RESET = 16'd1;
  localparam logic [PER_W-1:0]  PERIOD_RESET = 16'd10;

  typedef enum logic [1:0] {
    PHASE_V1    = 2'd0,
    PHASE_V2    = 2'd1,
    PHASE_BEGIN = 2'd2
  } phase_t;

  typedef struct packed {
    logic signed [SP_W-1:0] begin_uv;
    logic signed [SP_W-1:0] v1_uv;
    logic signed [SP_W-1:0] v2_uv;
    logic [STEP_W-1:0]      step_uv;
    logic [CYC_W-1:0]       cycle_total;
    logic [PER_W-1:0]       period_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [SP_W-1:0] setpoint;
    phase_t                 phase;
    logic                   going_down;
    logic [CYC_W-1:0]       cycle_count;
    logic [CNT_W-1:0]       sample_count;
    logic                   run_active;
  } sweep_state_t;

  typedef struct packed {
    logic data_valid;
    logic sweep_done;
  } step_flags_t;

  function automatic logic signed [SP_W-1:0] objective(phase_t phase, cfg_t cfg);
    logic signed [SP_W-1:0] obj;
    case (phase)
      PHASE_V1: obj = cfg.v1_uv;
      PHASE_V2: obj = cfg.v2_uv;
      default:  obj = cfg.begin_uv;
    endcase
    return obj;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/cvs_if.sv */
// Handshake interfaces for the sample channel and the result channel of the sweep sequencer.
// Depends on cvs_pkg for the field widths.
`default_nettype none

interface cvs_item_if;
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic signed [cvs_pkg::SP_W-1:0]  measured_voltage_uv;
  logic signed [cvs_pkg::CUR_W-1:0] measured_current_na;

  modport source (output valid, action, measured_voltage_uv, measured_current_na,
                  input ready);
  modport sink (input valid, action, measured_voltage_uv, measured_current_na,
                output ready);
endinterface

interface cvs_result_if;
  logic                             valid;
  logic                             ready;
  logic                             data_valid;
  logic [cvs_pkg::CNT_W-1:0]        point_index;
  logic [cvs_pkg::CNT_W-1:0]        elapsed_ms;
  logic signed [cvs_pkg::SP_W-1:0]  cell_voltage_uv;
  logic signed [cvs_pkg::CUR_W-1:0] cell_current_na;
  logic signed [cvs_pkg::SP_W-1:0]  setpoint_uv;
  logic                             relay_closed;
  logic                             sweep_done;

  modport source (output valid, data_valid, point_index, elapsed_ms, cell_voltage_uv,
                  cell_current_na, setpoint_uv, relay_closed, sweep_done,
                  input ready);
  modport sink (input valid, data_valid, point_index, elapsed_ms, cell_voltage_uv,
                cell_current_na, setpoint_uv, relay_closed, sweep_done,
                output ready);
endinterface

`default_nettype wire

/* hw/rtl/cvs_sweep_step.sv */
// Next-state logic of the sweep: start, setpoint stepping with clamp, and vertex turns.
// Depends on cvs_pkg for the state, configuration and flag types.
`default_nettype none

module cvs_sweep_step (
  input  wire  cvs_pkg::cfg_t         cfg,
  input  wire  cvs_pkg::sweep_state_t cur,
  input  wire  logic                  action,
  output cvs_pkg::sweep_state_t       nxt,
  output cvs_pkg::step_flags_t        flags
);

  logic signed [cvs_pkg::SP_W-1:0] obj;
  logic signed [cvs_pkg::SP_W+1:0] sp_ext;
  logic signed [cvs_pkg::SP_W+1:0] obj_ext;
  logic signed [cvs_pkg::SP_W+1:0] step_ext;
  logic signed [cvs_pkg::SP_W+1:0] lower;
  logic signed [cvs_pkg::SP_W+1:0] upper;

  assign obj      = cvs_pkg::objective(cur.phase, cfg);
  assign sp_ext   = (cvs_pkg::SP_W+2)'(cur.setpoint);
  assign obj_ext  = (cvs_pkg::SP_W+2)'(obj);
  assign step_ext = $signed({5'b0, cfg.step_uv});
  assign lower    = sp_ext - step_ext;
  assign upper    = sp_ext + step_ext;

  always_comb begin
    nxt   = cur;
    flags = '0;
    if (action == cvs_pkg::ACT_START) begin
      nxt.setpoint     = cfg.begin_uv;
      nxt.phase        = cvs_pkg::PHASE_V1;
      nxt.going_down   = cfg.v1_uv < cfg.begin_uv;
      nxt.cycle_count  = cvs_pkg::CYC_W'(1);
      nxt.sample_count = '0;
      nxt.run_active   = 1'b1;
    end else if (cur.run_active) begin
      flags.data_valid = 1'b1;
      nxt.sample_count = cur.sample_count + cvs_pkg::CNT_W'(1);
      if (cur.setpoint == obj) begin
        case (cur.phase)
          cvs_pkg::PHASE_V1: begin
            nxt.phase = cvs_pkg::PHASE_V2;
          end
          cvs_pkg::PHASE_V2: begin
            nxt.phase = cvs_pkg::PHASE_BEGIN;
          end
          default: begin
            if (cur.cycle_count >= cfg.cycle_total) begin
              nxt.run_active   = 1'b0;
              flags.sweep_done = 1'b1;
            end else begin
              nxt.cycle_count = cur.cycle_count + cvs_pkg::CYC_W'(1);
              nxt.phase       = cvs_pkg::PHASE_V1;
            end
          end
        endcase
        if (nxt.run_active) begin
          nxt.going_down = cvs_pkg::objective(nxt.phase, cfg) < cur.setpoint;
        end
      end else if (cur.going_down) begin
        nxt.setpoint = (lower < obj_ext) ? obj : lower[cvs_pkg::SP_W-1:0];
      end else begin
        nxt.setpoint = (upper > obj_ext) ? obj : upper[cvs_pkg::SP_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cyclic_voltammetry_sweep.sv */
// Latency: a result is valid in the cycle after its transaction is accepted on the item channel.
// One item per cycle while result.ready holds; the result register refills in the cycle it is taken.
// The elapsed time is one 32 by 16 multiply of the new point number, stored in the result register.
// Reset is synchronous and active high: all registers but the result data reset; the sweep is idle.
// Depends on cvs_pkg, the interfaces in cvs_if and cvs_sweep_step.
`default_nettype none

module cyclic_voltammetry_sweep (
  input  wire logic                           clk,
  input  wire logic                           rst,
  cvs_item_if.sink                            item,
  cvs_result_if.source                        result,
  input  wire logic                           cfg_we,
  input  wire logic [cvs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cvs_pkg::CFG_DATA_W-1:0] cfg_data
);

  cvs_pkg::cfg_t         cfg;
  cvs_pkg::sweep_state_t state;
  cvs_pkg::sweep_state_t state_next;
  cvs_pkg::step_flags_t  flags;

  logic accept;
  logic out_valid;
  logic [cvs_pkg::CNT_W+cvs_pkg::PER_W-1:0] product;

  logic                             data_valid;
  logic [cvs_pkg::CNT_W-1:0]        point_index;
  logic [cvs_pkg::CNT_W-1:0]        elapsed_ms;
  logic signed [cvs_pkg::SP_W-1:0]  cell_voltage_uv;
  logic signed [cvs_pkg::CUR_W-1:0] cell_current_na;
  logic signed [cvs_pkg::SP_W-1:0]  setpoint_uv;
  logic                             relay_closed;
  logic                             sweep_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.begin_uv    <= '0;
      cfg.v1_uv       <= '0;
      cfg.v2_uv       <= '0;
      cfg.step_uv     <= cvs_pkg::STEP_RESET;
      cfg.cycle_total <= cvs_pkg::CYCLES_RESET;
      cfg.period_ms   <= cvs_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cvs_pkg::REG_BEGIN:  cfg.begin_uv    <= cfg_data;
        cvs_pkg::REG_V1:     cfg.v1_uv       <= cfg_data;
        cvs_pkg::REG_V2:     cfg.v2_uv       <= cfg_data;
        cvs_pkg::REG_STEP:   cfg.step_uv     <= cfg_data[cvs_pkg::STEP_W-1:0];
        cvs_pkg::REG_CYCLES: cfg.cycle_total <= cfg_data[cvs_pkg::CYC_W-1:0];
        cvs_pkg::REG_PERIOD: cfg.period_ms   <= cfg_data[cvs_pkg::PER_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept     = item.valid && item.ready;
  assign item.ready = !out_valid || result.ready;

  cvs_sweep_step u_step (
    .cfg    (cfg),
    .cur    (state),
    .action (item.action),
    .nxt    (state_next),
    .flags  (flags)
  );

  assign product = state_next.sample_count * cfg.period_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.setpoint     <= '0;
      state.phase        <= cvs_pkg::PHASE_V1;
      state.going_down   <= 1'b0;
      state.cycle_count  <= cvs_pkg::CYC_W'(1);
      state.sample_count <= '0;
      state.run_active   <= 1'b0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_valid      <= flags.data_valid;
      point_index     <= flags.data_valid ? state_next.sample_count : '0;
      elapsed_ms      <= flags.data_valid ? product[cvs_pkg::CNT_W-1:0] : '0;
      cell_voltage_uv <= flags.data_valid ? item.measured_voltage_uv : '0;
      cell_current_na <= flags.data_valid ? item.measured_current_na : '0;
      setpoint_uv     <= state_next.setpoint;
      relay_closed    <= state_next.run_active;
      sweep_done      <= flags.sweep_done;
    end
  end

  assign result.valid           = out_valid;
  assign result.data_valid      = data_valid;
  assign result.point_index     = point_index;
  assign result.elapsed_ms      = elapsed_ms;
  assign result.cell_voltage_uv = cell_voltage_uv;
  assign result.cell_current_na = cell_current_na;
  assign result.setpoint_uv     = setpoint_uv;
  assign result.relay_closed    = relay_closed;
  assign result.sweep_done      = sweep_done;

  a_relay_tracks_run: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.relay_closed == state.run_active && result.setpoint_uv == state.setpoint)
    else $error("result relay or setpoint differs from the sweep state");

  a_done_opens_relay: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.sweep_done |-> !result.relay_closed && result.data_valid)
    else $error("sweep done reported with relay closed or without a data point");

  a_no_point_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.data_valid |-> result.point_index == '0 && result.elapsed_ms == '0)
    else $error("result without a data point carries a point number or time stamp");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    accept && item.action == cvs_pkg::ACT_START |=>
      state.run_active && state.sample_count == '0 && state.phase == cvs_pkg::PHASE_V1)
    else $error("start transaction did not restart the sweep");

  a_idle_tick_ignored: assert property (@(posedge clk) disable iff (rst)
    accept && item.action == cvs_pkg::ACT_TICK && !state.run_active |=>
      $stable(state.setpoint) && $stable(state.sample_count) && !state.run_active)
    else $error("tick while idle changed the sweep state");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the cyclic voltammetry sweep sequencer.
// A scoreboard class predicts each result; tasks drive the item channel and configuration port.
// Depends on cvs_pkg, the interfaces in cvs_if and the top level cyclic_voltammetry_sweep.

module tb_top;
  import cvs_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_UV = 4194303;
  localparam int MIN_UV = -4194304;

  typedef struct packed {
    logic                    data_valid;
    logic [CNT_W-1:0]        point_index;
    logic [CNT_W-1:0]        elapsed_ms;
    logic signed [SP_W-1:0]  cell_voltage_uv;
    logic signed [CUR_W-1:0] cell_current_na;
    logic signed [SP_W-1:0]  setpoint_uv;
    logic                    relay_closed;
    logic                    sweep_done;
  } sweep_point_t;

  class sweep_tracker;
    logic signed [SP_W-1:0] begin_uv;
    logic signed [SP_W-1:0] v1_uv;
    logic signed [SP_W-1:0] v2_uv;
    logic [STEP_W-1:0]      step_uv;
    logic [CYC_W-1:0]       cycle_total;
    logic [PER_W-1:0]       period_ms;
    int                     setpoint;
    phase_t                 phase;
    bit                     going_down;
    logic [CYC_W-1:0]       cycle_count;
    logic [CNT_W-1:0]       sample_count;
    logic [CNT_W-1:0]       time_total;
    bit                     run_active;
    sweep_point_t           points_due[$];
    int                     errors;
    int                     sweeps_done;
    int                     points_made;

    function new();
      begin_uv = '0;
      v1_uv = '0;
      v2_uv = '0;
      step_uv = STEP_RESET;
      cycle_total = CYCLES_RESET;
      period_ms = PERIOD_RESET;
      setpoint = 0;
      phase = PHASE_V1;
      going_down = 1'b0;
      cycle_count = 1;
      sample_count = '0;
      time_total = '0;
      run_active = 1'b0;
      errors = 0;
      sweeps_done = 0;
      points_made = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BEGIN:  begin_uv = data[SP_W-1:0];
        REG_V1:     v1_uv = data[SP_W-1:0];
        REG_V2:     v2_uv = data[SP_W-1:0];
        REG_STEP:   step_uv = data[STEP_W-1:0];
        REG_CYCLES: cycle_total = data[CYC_W-1:0];
        REG_PERIOD: period_ms = data[PER_W-1:0];
        default: ;
      endcase
    endfunction

    function int objective_uv();
      int obj;
      case (phase)
        PHASE_V1: obj = int'(v1_uv);
        PHASE_V2: obj = int'(v2_uv);
        default:  obj = int'(begin_uv);
      endcase
      return obj;
    endfunction

    function void note_item(logic act, logic signed [SP_W-1:0] v, logic signed [CUR_W-1:0] c);
      sweep_point_t p;
      int obj;
      int stp;
      p = '0;
      if (act == ACT_START) begin
        setpoint = int'(begin_uv);
        phase = PHASE_V1;
        going_down = v1_uv < begin_uv;
        cycle_count = 1;
        sample_count = '0;
        time_total = '0;
        run_active = 1'b1;
      end else if (run_active) begin
        p.data_valid = 1'b1;
        points_made++;
        sample_count = sample_count + 1;
        time_total = sample_count * period_ms;
        obj = objective_uv();
        if (setpoint == obj) begin
          case (phase)
            PHASE_V1: phase = PHASE_V2;
            PHASE_V2: phase = PHASE_BEGIN;
            default: begin
              if (cycle_count >= cycle_total) begin
                run_active = 1'b0;
                p.sweep_done = 1'b1;
                sweeps_done++;
              end else begin
                cycle_count = cycle_count + 1;
                phase = PHASE_V1;
              end
            end
          endcase
          if (run_active) going_down = objective_uv() < setpoint;
        end else begin
          stp = int'(step_uv);
          if (going_down) begin
            if (setpoint - stp < obj) setpoint = obj;
            else setpoint = setpoint - stp;
          end else begin
            if (setpoint + stp > obj) setpoint = obj;
            else setpoint = setpoint + stp;
          end
        end
        p.point_index = sample_count;
        p.elapsed_ms = time_total;
        p.cell_voltage_uv = v;
        p.cell_current_na = c;
      end
      p.setpoint_uv = setpoint[SP_W-1:0];
      p.relay_closed = run_active;
      points_due.push_back(p);
    endfunction

    function bit field_ok(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_point(sweep_point_t got);
      sweep_point_t want;
      bit ok;
      if (points_due.size() == 0) begin
        $display("%0t: result transaction with no pending item, actual %0h", $time, got);
        errors++;
        return;
      end
      want = points_due.pop_front();
      ok = 1'b1;
      ok &= field_ok("data_valid", want.data_valid, got.data_valid);
      ok &= field_ok("point_index", want.point_index, got.point_index);
      ok &= field_ok("elapsed_ms", want.elapsed_ms, got.elapsed_ms);
      ok &= field_ok("cell_voltage_uv", want.cell_voltage_uv, got.cell_voltage_uv);
      ok &= field_ok("cell_current_na", want.cell_current_na, got.cell_current_na);
      ok &= field_ok("setpoint_uv", want.setpoint_uv, got.setpoint_uv);
      ok &= field_ok("relay_closed", want.relay_closed, got.relay_closed);
      ok &= field_ok("sweep_done", want.sweep_done, got.sweep_done);
      if (!ok) errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cvs_item_if   item_ch ();
  cvs_result_if result_ch ();

  sweep_tracker book = new();

  int cycles_run = 0;
  int items_sent = 0;
  int points_seen = 0;
  int writes_done = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int extreme_pick = 0;

  logic signed [SP_W-1:0]  extreme_v [4] = '{-23'sd4194304, 23'sd4194303, 23'sd0, -23'sd1};
  logic signed [CUR_W-1:0] extreme_c [4] = '{-24'sd8388608, 24'sd8388607, 24'sd0, 24'sd1};

  cyclic_voltammetry_sweep DUT (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles_run++;
    if (cycles_run > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles.", cycles_run);
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && points_seen >= 320 && item_ch.valid) begin
      result_ch.ready <= 1'b0;
      hold_left <= 200;
      hold_done <= 1'b1;
    end else if (points_seen >= 450 && points_seen < 600) begin
      result_ch.ready <= 1'b1;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk) begin
    sweep_point_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.data_valid = result_ch.data_valid;
      got.point_index = result_ch.point_index;
      got.elapsed_ms = result_ch.elapsed_ms;
      got.cell_voltage_uv = result_ch.cell_voltage_uv;
      got.cell_current_na = result_ch.cell_current_na;
      got.setpoint_uv = result_ch.setpoint_uv;
      got.relay_closed = result_ch.relay_closed;
      got.sweep_done = result_ch.sweep_done;
      book.check_point(got);
      points_seen++;
    end
  end

  function automatic int clip_uv(int x);
    if (x > MAX_UV) return MAX_UV;
    if (x < MIN_UV) return MIN_UV;
    return x;
  endfunction

  task automatic send_item(logic act, logic signed [SP_W-1:0] v, logic signed [CUR_W-1:0] c);
    if ((items_sent < 250 || items_sent >= 400) && $urandom_range(99) < 13) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < 13) @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.action <= act;
    item_ch.measured_voltage_uv <= v;
    item_ch.measured_current_na <= c;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    book.note_item(act, v, c);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(logic act);
    if ($urandom_range(9) == 0)
      send_item(act, extreme_v[$urandom_range(3)], extreme_c[$urandom_range(3)]);
    else
      send_item(act, SP_W'($urandom), CUR_W'($urandom));
  endtask

  task automatic directed_run(int ticks);
    send_item(ACT_START, extreme_v[extreme_pick % 4], extreme_c[(extreme_pick + 1) % 4]);
    repeat (ticks) begin
      extreme_pick++;
      send_item(ACT_TICK, extreme_v[extreme_pick % 4], extreme_c[(extreme_pick + 3) % 4]);
    end
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    while (book.points_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    book.set_reg(idx, val[CFG_DATA_W-1:0]);
    writes_done++;
    @(negedge clk);
  endtask

  task automatic write_all(int b, int a1, int a2, int stp, int cyc, int per);
    write_reg(REG_BEGIN, b);
    write_reg(REG_V1, a1);
    write_reg(REG_V2, a2);
    write_reg(REG_STEP, stp);
    write_reg(REG_CYCLES, cyc);
    write_reg(REG_PERIOD, per);
    cfg_we <= 1'b0;
  endtask

  task automatic write_compact();
    int stp;
    int b;
    int a1;
    int a2;
    int d;
    int cyc;
    stp = ($urandom_range(3) == 0) ? int'($urandom_range(1, 1048575)) :
                                     int'($urandom_range(1, 4000));
    b = int'($urandom_range(0, 8388607)) - 4194304;
    d = int'($urandom_range(0, 5)) * stp + int'($urandom_range(0, stp));
    a1 = clip_uv(($urandom_range(1) == 1) ? b + d : b - d);
    d = int'($urandom_range(0, 5)) * stp + int'($urandom_range(0, stp));
    if ($urandom_range(4) == 0)
      a2 = clip_uv(($urandom_range(1) == 1) ? a1 + d : a1 - d);
    else
      a2 = clip_uv((a1 > b) ? a1 - d : a1 + d);
    cyc = ($urandom_range(5) == 0) ? int'($urandom_range(1, 65535)) :
                                     int'($urandom_range(1, 3));
    write_all(b, a1, a2, stp, cyc, int'($urandom_range(1, 65535)));
  endtask

  initial begin
    int count;
    item_ch.valid = 1'b0;
    item_ch.action = ACT_START;
    item_ch.measured_voltage_uv = '0;
    item_ch.measured_current_na = '0;
    cfg_we = 1'b0;
    cfg_index = REG_BEGIN;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, starting from the register defaults.
    send_item(ACT_TICK, extreme_v[0], extreme_c[1]);
    directed_run(3);
    send_item(ACT_TICK, extreme_v[1], extreme_c[0]);
    settle();
    write_all(MAX_UV, MIN_UV, MAX_UV, 1048575, 65535, 65535);
    directed_run(3);
    directed_run(2);
    settle();
    write_all(5, 5, 5, 0, 0, 1);
    directed_run(3);
    settle();
    write_all(0, 10, -10, 0, 1, 2);
    directed_run(2);
    settle();
    write_all(0, 3000, -3000, 1000, 1, 1);
    directed_run(1);
    settle();
    write_reg(REG_V1, -5000);
    cfg_we <= 1'b0;
    send_item(ACT_TICK, extreme_v[2], extreme_c[3]);
    send_item(ACT_TICK, extreme_v[3], extreme_c[2]);

    // Random part: mostly complete sweeps with random content.
    for (int ph = 0; ph < 12; ph++) begin
      settle();
      if (ph == 3)
        write_all(MIN_UV, MAX_UV, MIN_UV, 1048575, 2, 65535);
      else if (ph == 7)
        write_all(MAX_UV, MIN_UV, MAX_UV, 1048575, 65535, 1);
      else
        write_compact();
      count = 0;
      while (count < 50) begin
        if (!book.run_active) begin
          if ($urandom_range(99) < 20) begin
            send_random(ACT_TICK);
          end else begin
            send_random(ACT_START);
            count++;
          end
        end else begin
          send_random(($urandom_range(99) < 3) ? ACT_START : ACT_TICK);
          count++;
        end
      end
    end

    settle();
    repeat (8) @(negedge clk);
    $display("Sent %0d items: %0d data points, %0d finished sweeps, %0d register writes.",
             items_sent, book.points_made, book.sweeps_done, writes_done);
    if (book.errors == 0 && book.points_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("Errors: %0d, results still pending: %0d", book.errors, book.points_due.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/cvs_pkg.sv
hw/rtl/cvs_if.sv
hw/rtl/cvs_sweep_step.sv
hw/rtl/cyclic_voltammetry_sweep.sv
tb/sv/tb_top.sv
